[hdl/atpt_pkg.sv]
// ----------------------------------------------------------------------------
// atpt_pkg
// shared widths, codes and types of the address tally and promotion table
// ----------------------------------------------------------------------------
package atpt_pkg;

    localparam int ADDR_W     = 24;
    localparam int INDEX_W    = 48;
    localparam int TALLY_W    = 16;
    localparam int CLK_W      = 32;
    localparam int RATE_W     = 27;
    localparam int AGE_W      = 64;
    localparam int SLOT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // index * 3200 + rate / 2 stays below 2^60
    localparam int NUM_W      = 60;

    localparam int PENDING_DEF = 16;
    localparam int TRACKED_DEF = 32;

    localparam logic [TALLY_W-1:0] TALLY_MAX     = '1;
    localparam logic [TALLY_W-1:0] DEF_THRESHOLD = 16'd1;
    localparam logic [CLK_W-1:0]   DEF_IDLE      = 32'd16384;
    localparam logic [RATE_W-1:0]  DEF_RATE      = 27'd4000000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE      = 2'd2;

    typedef enum logic [1:0] {
        ST_COUNTED  = 2'd0,
        ST_TRACKED  = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    typedef struct packed {
        logic                start;
        logic [INDEX_W-1:0]  index;
        logic [RATE_W-1:0]   rate;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [CLK_W-1:0]   quot;
    } t_div_rsp;

endpackage

[hdl/address_tally_promotion_table_unit.sv]
// ----------------------------------------------------------------------------
// address_tally_promotion_table_unit
// counts access addresses in a pending table and promotes them to tracked slots
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// s_axis    in   tdata: access_address, sample_index
// m_axis    out  tdata: slot, newly_tracked, idle_reset, native_clock, tally
//                tuser: status
// cfg       in   write enable, register index, data
//
// an item's time is set by the 60 step serial divider that runs beside
// the table scans; a tracked scan reads each used slot in turn and a
// pending scan each used entry, so a long scan can stretch an item.
// both tables sit in registered-read memories, no clearing pass after reset.
// a new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module address_tally_promotion_table_unit
    import atpt_pkg::*;
#(
    parameter int PENDING_ENTRIES = PENDING_DEF,
    parameter int TRACKED_ENTRIES = TRACKED_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [71:0]            s_axis_tdata,  // access_address, sample_index
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // slot, newly_tracked, idle_reset, native_clock, tally
    output logic [55:0]            m_axis_tdata,
    output logic [1:0]             m_axis_tuser,  // status
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PI_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int PC_W = $clog2(PENDING_ENTRIES + 1);
    localparam int TI_W = (TRACKED_ENTRIES > 1) ? $clog2(TRACKED_ENTRIES) : 1;
    localparam int TC_W = $clog2(TRACKED_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TR_RD,
        S_TR_CK,
        S_PD_RD,
        S_PD_CK,
        S_MV_RD,
        S_MV_WR,
        S_APPEND,
        S_CHK,
        S_PROMOTE,
        S_CLK_RD,
        S_CLK_CK,
        S_CNT,
        S_OUT
    } t_state;

    // configuration
    logic [TALLY_W-1:0] r_cfg_thr;
    logic [CLK_W-1:0]   r_cfg_idle;
    logic [RATE_W-1:0]  r_cfg_rate;

    // memories
    logic [ADDR_W-1:0]  pa_mem [PENDING_ENTRIES];
    logic [TALLY_W-1:0] pt_mem [PENDING_ENTRIES];
    logic [AGE_W-1:0]   pg_mem [PENDING_ENTRIES];
    logic [ADDR_W-1:0]  ta_mem [TRACKED_ENTRIES];
    logic [CLK_W-1:0]   tc_mem [TRACKED_ENTRIES];

    logic [ADDR_W-1:0]  r_pa_q;
    logic [TALLY_W-1:0] r_pt_q;
    logic [AGE_W-1:0]   r_pg_q;
    logic [ADDR_W-1:0]  r_ta_q;
    logic [CLK_W-1:0]   r_tc_q;

    logic               p_re, p_we;
    logic [PI_W-1:0]    p_ra, p_wa;
    logic [ADDR_W-1:0]  p_wd_a;
    logic [TALLY_W-1:0] p_wd_t;
    logic [AGE_W-1:0]   p_wd_g;
    logic               t_re, t_we_a, t_we_c;
    logic [TI_W-1:0]    t_ra, t_wa;
    logic [CLK_W-1:0]   t_wd_c;

    // control and item state
    t_state                r_state;
    logic [PC_W-1:0]       r_pused;
    logic [TC_W-1:0]       r_tused;
    logic [AGE_W-1:0]      r_ctr;
    logic [TRACKED_ENTRIES-1:0] r_seen;
    logic [TC_W-1:0]       r_ti;
    logic [PC_W-1:0]       r_pi;
    logic [PI_W-1:0]       r_vict;
    logic [PI_W-1:0]       r_dst;
    logic                  r_to_promote;
    logic [AGE_W-1:0]      r_best;
    logic [ADDR_W-1:0]     r_addr;
    logic [TALLY_W-1:0]    r_thr;
    logic [TALLY_W-1:0]    r_tally;
    logic [TI_W-1:0]       r_slot;
    logic                  r_fresh;

    // result
    t_status               r_st;
    logic                  r_flag;
    logic [CLK_W-1:0]      r_clk;
    logic                  r_ov;
    t_status               r_o_st;
    logic [SLOT_W-1:0]     r_o_slot;
    logic                  r_o_fresh;
    logic                  r_o_flag;
    logic [CLK_W-1:0]      r_o_clk;
    logic [TALLY_W-1:0]    r_o_tally;

    t_div_req              div_req;
    t_div_rsp              div_rsp;

    logic                  in_acc;
    logic [ADDR_W-1:0]     in_addr;
    logic [INDEX_W-1:0]    in_index;
    logic [TALLY_W-1:0]    sat_tally;
    logic [CLK_W-1:0]      gap;

    assign in_addr   = s_axis_tdata[ADDR_W-1:0];
    assign in_index  = s_axis_tdata[ADDR_W +: INDEX_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign sat_tally = (r_pt_q == TALLY_MAX) ? r_pt_q : r_pt_q + 1'b1;
    assign gap       = div_rsp.quot - r_tc_q;

    assign div_req.start = in_acc && (r_cfg_rate != '0);
    assign div_req.index = in_index;
    assign div_req.rate  = r_cfg_rate;

    atpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thr  <= DEF_THRESHOLD;
            r_cfg_idle <= DEF_IDLE;
            r_cfg_rate <= DEF_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD: r_cfg_thr  <= i_cfg_data[TALLY_W-1:0];
                REG_IDLE:      r_cfg_idle <= i_cfg_data[CLK_W-1:0];
                REG_RATE:      r_cfg_rate <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // memory port control
    always_comb begin
        p_re   = 1'b0;
        p_ra   = r_pi[PI_W-1:0];
        p_we   = 1'b0;
        p_wa   = r_pi[PI_W-1:0];
        p_wd_a = r_addr;
        p_wd_t = sat_tally;
        p_wd_g = r_ctr + 1'b1;
        t_re   = 1'b0;
        t_ra   = r_ti[TI_W-1:0];
        t_we_a = 1'b0;
        t_we_c = 1'b0;
        t_wa   = r_slot;
        t_wd_c = div_rsp.quot;
        case (r_state)
            S_TR_RD: t_re = (r_ti < r_tused);
            S_PD_RD: p_re = (r_pi < r_pused);
            S_PD_CK: p_we = (r_pa_q == r_addr);
            S_MV_RD: begin
                p_re = 1'b1;
                p_ra = PI_W'(r_pused - 1'b1);
            end
            S_MV_WR: begin
                p_we   = 1'b1;
                p_wa   = r_dst;
                p_wd_a = r_pa_q;
                p_wd_t = r_pt_q;
                p_wd_g = r_pg_q;
            end
            S_APPEND: begin
                p_we   = 1'b1;
                p_wa   = r_pused[PI_W-1:0];
                p_wd_t = TALLY_W'(1);
            end
            S_PROMOTE: begin
                t_we_a = (r_tused < TC_W'(TRACKED_ENTRIES));
                t_wa   = r_tused[TI_W-1:0];
            end
            S_CLK_RD: begin
                t_re = 1'b1;
                t_ra = r_slot;
            end
            S_CLK_CK: t_we_c = div_rsp.done
                && (!r_seen[r_slot] || (div_rsp.quot >= r_tc_q));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            pa_mem[p_wa] <= p_wd_a;
            pt_mem[p_wa] <= p_wd_t;
            pg_mem[p_wa] <= p_wd_g;
        end
        if (p_re) begin
            r_pa_q <= pa_mem[p_ra];
            r_pt_q <= pt_mem[p_ra];
            r_pg_q <= pg_mem[p_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we_a) begin
            ta_mem[t_wa] <= r_addr;
        end
        if (t_we_c) begin
            tc_mem[t_wa] <= t_wd_c;
        end
        if (t_re) begin
            r_ta_q <= ta_mem[t_ra];
            r_tc_q <= tc_mem[t_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pused <= '0;
            r_tused <= '0;
            r_ctr   <= '0;
            r_seen  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_addr  <= in_addr;
                        r_thr   <= (r_cfg_thr == '0) ? TALLY_W'(1) : r_cfg_thr;
                        r_ti    <= '0;
                        r_tally <= '0;
                        r_fresh <= 1'b0;
                        r_flag  <= 1'b0;
                        if (r_cfg_rate == '0) begin
                            r_st    <= ST_REJECTED;
                            r_slot  <= '0;
                            r_clk   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_TR_RD;
                        end
                    end
                end
                S_TR_RD: begin
                    if (r_ti < r_tused) begin
                        r_state <= S_TR_CK;
                    end else begin
                        r_pi    <= '0;
                        r_best  <= '1;
                        r_vict  <= '0;
                        r_state <= S_PD_RD;
                    end
                end
                S_TR_CK: begin
                    if (r_ta_q == r_addr) begin
                        r_slot  <= r_ti[TI_W-1:0];
                        r_state <= S_CLK_RD;
                    end else begin
                        r_ti    <= r_ti + 1'b1;
                        r_state <= S_TR_RD;
                    end
                end
                S_PD_RD: begin
                    if (r_pi < r_pused) begin
                        r_state <= S_PD_CK;
                    end else if (r_pused >= PC_W'(PENDING_ENTRIES)) begin
                        r_dst        <= r_vict;
                        r_to_promote <= 1'b0;
                        r_state      <= S_MV_RD;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_PD_CK: begin
                    if (r_pa_q == r_addr) begin
                        r_tally <= sat_tally;
                        r_ctr   <= r_ctr + 1'b1;
                        r_dst   <= r_pi[PI_W-1:0];
                        r_state <= S_CHK;
                    end else begin
                        if (r_pg_q < r_best) begin
                            r_best <= r_pg_q;
                            r_vict <= r_pi[PI_W-1:0];
                        end
                        r_pi    <= r_pi + 1'b1;
                        r_state <= S_PD_RD;
                    end
                end
                S_MV_RD: r_state <= S_MV_WR;
                S_MV_WR: begin
                    r_pused <= r_pused - 1'b1;
                    r_state <= r_to_promote ? S_PROMOTE : S_APPEND;
                end
                S_APPEND: begin
                    r_ctr   <= r_ctr + 1'b1;
                    r_dst   <= r_pused[PI_W-1:0];
                    r_pused <= r_pused + 1'b1;
                    r_tally <= TALLY_W'(1);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_tally < r_thr) begin
                        r_st    <= ST_COUNTED;
                        r_slot  <= '0;
                        r_state <= S_CNT;
                    end else begin
                        r_to_promote <= 1'b1;
                        r_state      <= S_MV_RD;
                    end
                end
                S_PROMOTE: begin
                    if (r_tused < TC_W'(TRACKED_ENTRIES)) begin
                        r_slot  <= r_tused[TI_W-1:0];
                        r_seen[r_tused[TI_W-1:0]] <= 1'b0;
                        r_tused <= r_tused + 1'b1;
                        r_fresh <= 1'b1;
                        r_state <= S_CLK_RD;
                    end else begin
                        r_st    <= ST_REJECTED;
                        r_slot  <= '0;
                        r_clk   <= '0;
                        r_tally <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_CLK_RD: r_state <= S_CLK_CK;
                S_CLK_CK: begin
                    if (div_rsp.done) begin
                        r_st   <= ST_TRACKED;
                        r_clk  <= div_rsp.quot;
                        r_flag <= r_seen[r_slot] && (div_rsp.quot >= r_tc_q)
                            && (r_cfg_idle != '0) && (gap > r_cfg_idle);
                        r_seen[r_slot] <= 1'b1;
                        if (!r_fresh) begin
                            r_tally <= '0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_CNT: begin
                    if (div_rsp.done) begin
                        r_clk   <= div_rsp.quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_o_st    <= r_st;
                        r_o_slot  <= SLOT_W'(r_slot);
                        r_o_fresh <= r_fresh;
                        r_o_flag  <= r_flag;
                        r_o_clk   <= r_clk;
                        r_o_tally <= r_tally;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_st;
    assign m_axis_tdata  = {1'b0, r_o_tally, r_o_clk, r_o_flag, r_o_fresh, r_o_slot};

`ifndef SYNTH
    a_pused_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pused <= PC_W'(PENDING_ENTRIES))
        else $error("pending count beyond table depth");

    a_tused_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tused <= TC_W'(TRACKED_ENTRIES))
        else $error("tracked count beyond table depth");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_REJECTED) |-> (m_axis_tdata == '0))
        else $error("rejected beat carries payload");

    a_counted_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_COUNTED)
            |-> (!r_o_fresh && !r_o_flag && r_o_tally != '0))
        else $error("counted beat with tracking flags");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input taken while an item is in work");
`endif

endmodule

[hdl/atpt_div.sv]
// ----------------------------------------------------------------------------
// atpt_div
// native clock from sample index: (index * 3200 + rate / 2) / rate, bit serial
// ----------------------------------------------------------------------------
module atpt_div
    import atpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } t_dstate;

    t_dstate             r_state;
    logic                r_done;
    logic [NUM_W-1:0]    r_num;
    logic [INDEX_W-1:0]  r_index;
    logic [RATE_W-1:0]   r_rate;
    logic [RATE_W-1:0]   r_rem;
    logic [CLK_W-1:0]    r_quot;
    logic [CNT_W-1:0]    r_cnt;

    logic [NUM_W-1:0]    ext_idx;
    logic [RATE_W:0]     trial;
    logic                qbit;

    assign ext_idx = NUM_W'(r_index);
    assign trial   = {r_rem, r_num[NUM_W-1]};
    assign qbit    = (trial >= {1'b0, r_rate});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else if (i_req.start) begin
            r_index <= i_req.index;
            r_rate  <= i_req.rate;
            r_done  <= 1'b0;
            r_state <= D_MUL;
            r_num   <= (NUM_W'(i_req.index) << 11) + (NUM_W'(i_req.index) << 10);
        end else begin
            case (r_state)
                D_MUL: begin
                    r_num   <= r_num + (ext_idx << 7) + NUM_W'(r_rate >> 1);
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(NUM_W - 1);
                    r_state <= D_DIV;
                end
                D_DIV: begin
                    r_rem  <= qbit ? RATE_W'(trial - {1'b0, r_rate}) : RATE_W'(trial);
                    r_num  <= r_num << 1;
                    r_quot <= {r_quot[CLK_W-2:0], qbit};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
